>>> rtl/rs2i_pkg.sv
// ============================================================================
// rs2i_pkg
// Shared types, character codes and the digit decode function for the
// radix string to 64-bit integer converter.
// ============================================================================
package rs2i_pkg;

    localparam int CH_W     = 8;
    localparam int RADIX_W  = 6;
    localparam int DIGIT_W  = 7;
    localparam int MAG_W    = 63;
    localparam int VALUE_W  = 64;
    localparam int ACC_W    = MAG_W + RADIX_W;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_DIG0  = 8'h30;
    localparam logic [CH_W-1:0] CH_DIG9  = 8'h39;
    localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7A;

    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 7'd10;
    localparam logic [DIGIT_W-1:0] NO_DIGIT  = 7'd64;

    // Parse state carried from one character to the next.
    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             is_neg;
        logic             at_start;
        logic             have_digit;
        logic             stopped;
        logic             pend_min;
    } parse_state_t;

    localparam parse_state_t STATE_CLEAR = '{
        mag:        '0,
        is_neg:     1'b0,
        at_start:   1'b1,
        have_digit: 1'b0,
        stopped:    1'b0,
        pend_min:   1'b0
    };

    // Result of one step, handed to the output stage.
    typedef struct packed {
        logic               emit;
        logic [VALUE_W-1:0] value;
        logic               error;
    } step_result_t;

    // Value of a digit character, or NO_DIGIT when the byte is not a digit.
    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CH_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        begin
            d = NO_DIGIT;
            if (c >= CH_DIG0 && c <= CH_DIG9)
            begin
                d = DIGIT_W'(c - CH_DIG0);
            end
            else if (c >= CH_UP_A && c <= CH_UP_Z)
            begin
                d = DIGIT_W'(c - CH_UP_A) + DIGIT_TEN;
            end
            else if (c >= CH_LO_A && c <= CH_LO_Z)
            begin
                d = DIGIT_W'(c - CH_LO_A) + DIGIT_TEN;
            end
            return d;
        end
    endfunction

endpackage

>>> rtl/rs2i_step.sv
// ============================================================================
// rs2i_step
// Combinational parse step: next state and result for one character.
// ============================================================================
module rs2i_step (
    input  rs2i_pkg::parse_state_t             cur,
    input  logic [rs2i_pkg::CH_W-1:0]          ch,
    input  logic [rs2i_pkg::RADIX_W-1:0]       radix,
    output rs2i_pkg::parse_state_t             nxt,
    output rs2i_pkg::step_result_t             res
);

    logic [rs2i_pkg::DIGIT_W-1:0] digit;
    logic [rs2i_pkg::ACC_W-1:0]   acc;
    logic                         acc_over;
    logic                         acc_min;
    logic                         sign_taken;

    assign digit = rs2i_pkg::digit_of(ch);

    // One 63x6 multiply-add; anything at or above 2^63 overflows.
    assign acc = rs2i_pkg::ACC_W'(cur.mag) * rs2i_pkg::ACC_W'(radix)
               + rs2i_pkg::ACC_W'(digit);
    assign acc_over = (acc[rs2i_pkg::ACC_W-1:rs2i_pkg::MAG_W] != '0);
    assign acc_min  = (acc[rs2i_pkg::ACC_W-1:rs2i_pkg::MAG_W] == rs2i_pkg::RADIX_W'(1))
                   && (acc[rs2i_pkg::MAG_W-1:0] == '0);

    assign sign_taken = cur.at_start && (ch == rs2i_pkg::CH_MINUS || ch == rs2i_pkg::CH_PLUS);

    always_comb
    begin
        res.emit = (ch == rs2i_pkg::CH_NUL);
        if (cur.pend_min)
        begin
            res.value = {1'b1, {rs2i_pkg::MAG_W{1'b0}}};
            res.error = 1'b0;
        end
        else
        begin
            res.value = cur.is_neg ? (rs2i_pkg::VALUE_W'(0) - {1'b0, cur.mag})
                                   : {1'b0, cur.mag};
            res.error = cur.stopped || !cur.have_digit;
        end
    end

    always_comb
    begin
        nxt = cur;
        if (ch == rs2i_pkg::CH_NUL)
        begin
            nxt = rs2i_pkg::STATE_CLEAR;
        end
        else if (cur.stopped)
        begin
            nxt = cur;
        end
        else if (cur.pend_min)
        begin
            // Anything after a magnitude of exactly 2^63 is an overflow.
            nxt.pend_min = 1'b0;
            nxt.stopped  = 1'b1;
        end
        else
        begin
            nxt.at_start = 1'b0;
            if (sign_taken)
            begin
                nxt.is_neg = (ch == rs2i_pkg::CH_MINUS);
            end
            else if (digit >= rs2i_pkg::DIGIT_W'(radix))
            begin
                nxt.stopped = 1'b1;
            end
            else if (acc_over)
            begin
                if (cur.is_neg && acc_min)
                begin
                    nxt.pend_min = 1'b1;
                end
                else
                begin
                    nxt.stopped = 1'b1;
                end
            end
            else
            begin
                nxt.mag        = acc[rs2i_pkg::MAG_W-1:0];
                nxt.have_digit = 1'b1;
            end
        end
    end

endmodule

>>> rtl/rs2i_out_stage.sv
// ============================================================================
// rs2i_out_stage
// Result register holding one finished conversion until it is taken.
// ============================================================================
module rs2i_out_stage (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  logic [rs2i_pkg::VALUE_W-1:0]     value,
    input  logic                             error,
    output logic                             space,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rs2i_pkg::VALUE_W-1:0]     m_tdata,
    output logic                             m_tuser
);

    logic                         valid_reg;
    logic                         valid_next;
    logic [rs2i_pkg::VALUE_W-1:0] value_reg;
    logic                         error_reg;

    // A slot frees up in the same cycle that the held result is taken.
    assign space = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= value;
            error_reg <= error;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = value_reg;
    assign m_tuser  = error_reg;

endmodule

>>> rtl/radix_string_to_int64_core.sv
// ============================================================================
// radix_string_to_int64_core
// Converts a zero-terminated character stream into a signed 64-bit integer.
// ============================================================================
// Usage: characters enter one byte per transfer on the slave stream (s_*).
// An optional leading '-' or '+' is allowed, then digits 0-9, A-Z, a-z in
// the radix held by the configuration register (written on cfg_* while the
// block is idle, 10 after reset). A zero byte ends the string and produces
// one result transfer on the master stream (m_*): the signed value in tdata
// and an error flag in tuser. Other bytes produce no result.
// Throughput is one character per cycle while s_tready is high; the parse
// state is updated by one 63x6 multiply-add and compare per character. The
// result appears on m_* in the cycle after the terminating byte is accepted.
// A finished result waits in the output register; while it waits, further
// characters keep being accepted as long as the register is free or is
// being drained in the same cycle. If the receiver stalls with a result
// held, s_tready drops until the result is taken.
// Reset clears the parse state, empties the output register and sets the
// radix back to 10. After a bad character or overflow the rest of the
// string is skipped and the terminator reports error with the partial value.
// ============================================================================
module radix_string_to_int64_core (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration: radix.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rs2i_pkg::RADIX_W-1:0]     cfg_data,
    // Input stream. tdata: [7:0] ch.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rs2i_pkg::CH_W-1:0]        s_tdata,
    // Output stream. tdata: [63:0] value. tuser: [0] error.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rs2i_pkg::VALUE_W-1:0]     m_tdata,
    output logic                             m_tuser
);

    logic [rs2i_pkg::RADIX_W-1:0] radix_reg;
    logic [rs2i_pkg::RADIX_W-1:0] radix_next;
    rs2i_pkg::parse_state_t       state_reg;
    rs2i_pkg::parse_state_t       state_next;
    rs2i_pkg::parse_state_t       step_state;
    rs2i_pkg::step_result_t       step_res;
    logic                         in_xfer;
    logic                         out_space;

    // The radix register accepts a write in any cycle.
    assign cfg_ready = 1'b1;

    assign s_tready = out_space;
    assign in_xfer  = s_tvalid && s_tready;

    always_comb
    begin
        radix_next = radix_reg;
        if (cfg_valid && cfg_ready)
        begin
            radix_next = cfg_data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (in_xfer)
        begin
            state_next = step_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= rs2i_pkg::RADIX_RESET;
            state_reg <= rs2i_pkg::STATE_CLEAR;
        end
        else
        begin
            radix_reg <= radix_next;
            state_reg <= state_next;
        end
    end

    rs2i_step u_step (
        .cur   (state_reg),
        .ch    (s_tdata),
        .radix (radix_reg),
        .nxt   (step_state),
        .res   (step_res)
    );

    // Only the terminating byte loads a result.
    rs2i_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_xfer && step_res.emit),
        .value    (step_res.value),
        .error    (step_res.error),
        .space    (out_space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
